// ===== hdl/scp_pkg.sv =====
// shared constants for the segment closest points unit
package scp_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int PARAM_FRAC = 32;
   localparam int MUL_CHUNK = 16;
   localparam logic [31:0] LIMIT_RESET = 32'd4295;

endpackage

// ===== hdl/segment_closest_points_unit.sv =====
// top level: closest points between two 3d segments, fully pipelined
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     two segments, 12 coordinates
//   rsp_      out         rsp_valid / rsp_stall     two near points, 6 coordinates
//   csr_      in          csr_wr_en                 degenerate limit
//
// one transfer per cycle while the result is not stalled
// reset clears the valid bits and loads the limit register
// a stalled result freezes the whole pipeline; nothing is lost or repeated
module segment_closest_points_unit import scp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_first_start_x,
   input  logic [COORD_BITS-1:0] req_first_start_y,
   input  logic [COORD_BITS-1:0] req_first_start_z,
   input  logic [COORD_BITS-1:0] req_first_end_x,
   input  logic [COORD_BITS-1:0] req_first_end_y,
   input  logic [COORD_BITS-1:0] req_first_end_z,
   input  logic [COORD_BITS-1:0] req_second_start_x,
   input  logic [COORD_BITS-1:0] req_second_start_y,
   input  logic [COORD_BITS-1:0] req_second_start_z,
   input  logic [COORD_BITS-1:0] req_second_end_x,
   input  logic [COORD_BITS-1:0] req_second_end_y,
   input  logic [COORD_BITS-1:0] req_second_end_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_near_first_x,
   output logic [COORD_BITS-1:0] rsp_near_first_y,
   output logic [COORD_BITS-1:0] rsp_near_first_z,
   output logic [COORD_BITS-1:0] rsp_near_second_x,
   output logic [COORD_BITS-1:0] rsp_near_second_y,
   output logic [COORD_BITS-1:0] rsp_near_second_z
);

   localparam int PF = PARAM_FRAC;
   localparam int CH = MUL_CHUNK;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int DOTW = PW + 2;
   localparam int QW = 2 * DOTW + 1;
   localparam int LM1 = (DOTW + CH - 1) / CH;
   localparam int LD = PF + 1;
   localparam int LM2 = (PF + 2 + CH - 1) / CH;
   localparam int WP2 = DOTW + PF + 2;
   localparam int TW = DOTW + PF + 3;
   localparam int PTW = DW + PF + 3;
   localparam int SHW = DW + 3;
   localparam int T1 = LM1 + 1 + LD;
   localparam int T2 = T1 + LM2 + 2;
   localparam int NCTX = T2 + LD + 1;
   localparam int NV = NCTX + 4;
   localparam logic [PF:0] ONE_P = {1'b1, {PF{1'b0}}};

   typedef struct packed {
      logic [2:0][COORD_BITS-1:0] p1;
      logic [2:0][COORD_BITS-1:0] p2;
      logic [2:0][DW-1:0]         d1;
      logic [2:0][DW-1:0]         d2;
      logic [DOTW-1:0]            a;
      logic [DOTW-1:0]            b;
      logic [DOTW-1:0]            c;
      logic [DOTW-1:0]            e;
      logic [DOTW-1:0]            f;
      logic                       deg1;
      logic                       deg2;
   } ctx_type;

   typedef struct packed {
      logic        to_t;
      logic [PF:0] s_fix;
      logic [PF:0] t_fix;
   } flag_type;

   typedef struct packed {
      flag_type      fl;
      logic [TW-1:0] num;
      logic [TW-1:0] den;
   } sel_type;

   function automatic logic [COORD_BITS-1:0] sat_f(input logic [SHW-1:0] v);
      logic signed [SHW-1:0] hi;
      logic signed [SHW-1:0] lo;
      hi = {{5{1'b0}}, {(COORD_BITS-1){1'b1}}};
      lo = {{5{1'b1}}, {(COORD_BITS-1){1'b0}}};
      if ($signed(v) > hi) begin
         return hi[COORD_BITS-1:0];
      end else if ($signed(v) < lo) begin
         return lo[COORD_BITS-1:0];
      end
      return v[COORD_BITS-1:0];
   endfunction

   logic                       en;
   logic [NV-1:0]              v_ff;
   logic [31:0]                limit_ff;
   logic [2:0][COORD_BITS-1:0] in_p1, in_e1, in_p2, in_e2;

   logic [2:0][COORD_BITS-1:0] p1_ff, p2_ff, p1b_ff, p2b_ff;
   logic [2:0][DW-1:0]         d1_ff, d2_ff, r_ff, d1b_ff, d2b_ff;
   logic [2:0][PW-1:0]         pa_ff, pe_ff, pb_ff, pc_ff, pf_ff;
   ctx_type                    ctx_ff [NCTX];
   ctx_type                    ctx1_in;

   logic [2*DOTW-1:0]          ae_p, bb_p, bf_p, ce_p;
   logic [QW-1:0]              den_ff, num_ff;
   logic [PF:0]                q1, q2;
   logic [WP2-1:0]             bs_p;
   logic [PF:0]                s1_ff [LM2];
   logic [TW-1:0]              tnum_ff;
   logic [PF:0]                s1e_ff;
   sel_type                    sel_in, sel_ff;
   flag_type                   fl_ff [LD];
   logic [PF:0]                s_fin, t_fin;
   logic [2:0][DW+PF+1:0]      pr1_ff, pr2_ff;
   logic [2:0][COORD_BITS-1:0] st1_ff, st2_ff;
   logic [2:0][COORD_BITS-1:0] nf_ff, ns_ff;

   assign en = !(v_ff[NV-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = v_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NV-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   assign in_p1 = {req_first_start_z, req_first_start_y, req_first_start_x};
   assign in_e1 = {req_first_end_z, req_first_end_y, req_first_end_x};
   assign in_p2 = {req_second_start_z, req_second_start_y, req_second_start_x};
   assign in_e2 = {req_second_end_z, req_second_end_y, req_second_end_x};

   // directions, offset, then the fifteen products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            p1_ff[k] <= in_p1[k];
            p2_ff[k] <= in_p2[k];
            d1_ff[k] <= DW'($signed(in_e1[k])) - DW'($signed(in_p1[k]));
            d2_ff[k] <= DW'($signed(in_e2[k])) - DW'($signed(in_p2[k]));
            r_ff[k] <= DW'($signed(in_p1[k])) - DW'($signed(in_p2[k]));
            p1b_ff[k] <= p1_ff[k];
            p2b_ff[k] <= p2_ff[k];
            d1b_ff[k] <= d1_ff[k];
            d2b_ff[k] <= d2_ff[k];
            pa_ff[k] <= $signed(d1_ff[k]) * $signed(d1_ff[k]);
            pe_ff[k] <= $signed(d2_ff[k]) * $signed(d2_ff[k]);
            pb_ff[k] <= $signed(d1_ff[k]) * $signed(d2_ff[k]);
            pc_ff[k] <= $signed(d1_ff[k]) * $signed(r_ff[k]);
            pf_ff[k] <= $signed(d2_ff[k]) * $signed(r_ff[k]);
         end
      end
   end

   // degenerate flags join the context one stage after the dot products
   always_comb begin
      ctx1_in = ctx_ff[0];
      ctx1_in.deg1 = $signed(ctx_ff[0].a) <= $signed({{(DOTW-32){1'b0}}, limit_ff});
      ctx1_in.deg2 = $signed(ctx_ff[0].e) <= $signed({{(DOTW-32){1'b0}}, limit_ff});
   end

   // dot products and the context line
   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0].p1 <= p1b_ff;
         ctx_ff[0].p2 <= p2b_ff;
         ctx_ff[0].d1 <= d1b_ff;
         ctx_ff[0].d2 <= d2b_ff;
         ctx_ff[0].a <= DOTW'($signed(pa_ff[0])) + DOTW'($signed(pa_ff[1]))
                        + DOTW'($signed(pa_ff[2]));
         ctx_ff[0].e <= DOTW'($signed(pe_ff[0])) + DOTW'($signed(pe_ff[1]))
                        + DOTW'($signed(pe_ff[2]));
         ctx_ff[0].b <= DOTW'($signed(pb_ff[0])) + DOTW'($signed(pb_ff[1]))
                        + DOTW'($signed(pb_ff[2]));
         ctx_ff[0].c <= DOTW'($signed(pc_ff[0])) + DOTW'($signed(pc_ff[1]))
                        + DOTW'($signed(pc_ff[2]));
         ctx_ff[0].f <= DOTW'($signed(pf_ff[0])) + DOTW'($signed(pf_ff[1]))
                        + DOTW'($signed(pf_ff[2]));
         ctx_ff[0].deg1 <= 1'b0;
         ctx_ff[0].deg2 <= 1'b0;
         ctx_ff[1] <= ctx1_in;
         for (int i = 2; i < NCTX; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
      end
   end

   scp_mul #(.WA(DOTW), .WB(DOTW), .CH(CH)) u_mul_ae (
      .clock(clock), .en(en), .a_in(ctx_ff[0].a), .b_in(ctx_ff[0].e), .p_out(ae_p));
   scp_mul #(.WA(DOTW), .WB(DOTW), .CH(CH)) u_mul_bb (
      .clock(clock), .en(en), .a_in(ctx_ff[0].b), .b_in(ctx_ff[0].b), .p_out(bb_p));
   scp_mul #(.WA(DOTW), .WB(DOTW), .CH(CH)) u_mul_bf (
      .clock(clock), .en(en), .a_in(ctx_ff[0].b), .b_in(ctx_ff[0].f), .p_out(bf_p));
   scp_mul #(.WA(DOTW), .WB(DOTW), .CH(CH)) u_mul_ce (
      .clock(clock), .en(en), .a_in(ctx_ff[0].c), .b_in(ctx_ff[0].e), .p_out(ce_p));

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= QW'($signed(ae_p)) - QW'($signed(bb_p));
         num_ff <= QW'($signed(bf_p)) - QW'($signed(ce_p));
      end
   end

   // s on the infinite lines, clamped to [0, 1], zero when parallel
   scp_div #(.W(QW), .QB(PF)) u_div_s (
      .clock(clock), .en(en), .num_in(num_ff), .den_in(den_ff), .q_out(q1));

   scp_mul #(.WA(DOTW), .WB(PF+2), .CH(CH)) u_mul_bs (
      .clock(clock), .en(en), .a_in(ctx_ff[T1].b), .b_in({1'b0, q1}), .p_out(bs_p));

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff[0] <= q1;
         for (int i = 1; i < LM2; i++) begin
            s1_ff[i] <= s1_ff[i-1];
         end
         tnum_ff <= TW'($signed(bs_p)) + (TW'($signed(ctx_ff[T1+LM2].f)) <<< PF);
         s1e_ff <= s1_ff[LM2-1];
      end
   end

   // pick the second division and where its quotient goes
   always_comb begin
      logic [TW-1:0] tden;
      logic          gt;
      ctx_type       x;
      x = ctx_ff[T1+LM2+1];
      tden = TW'($signed(x.e)) <<< PF;
      gt = $signed(tnum_ff) > $signed(tden);
      sel_in.fl.to_t = 1'b0;
      sel_in.fl.s_fix = '0;
      sel_in.fl.t_fix = '0;
      sel_in.num = '0;
      sel_in.den = TW'($signed(x.a));
      if (x.deg1 && x.deg2) begin
         sel_in.num = '0;
      end else if (x.deg1) begin
         sel_in.fl.to_t = 1'b1;
         sel_in.num = TW'($signed(x.f));
         sel_in.den = TW'($signed(x.e));
      end else if (x.deg2 || tnum_ff[TW-1]) begin
         sel_in.num = -TW'($signed(x.c));
      end else if (gt) begin
         sel_in.fl.t_fix = ONE_P;
         sel_in.num = TW'($signed(x.b)) - TW'($signed(x.c));
      end else begin
         sel_in.fl.to_t = 1'b1;
         sel_in.fl.s_fix = s1e_ff;
         sel_in.num = tnum_ff;
         sel_in.den = tden;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sel_ff <= sel_in;
         fl_ff[0] <= sel_ff.fl;
         for (int i = 1; i < LD; i++) begin
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   scp_div #(.W(TW), .QB(PF)) u_div_f (
      .clock(clock), .en(en), .num_in(sel_ff.num), .den_in(sel_ff.den), .q_out(q2));

   assign s_fin = fl_ff[LD-1].to_t ? fl_ff[LD-1].s_fix : q2;
   assign t_fin = fl_ff[LD-1].to_t ? q2 : fl_ff[LD-1].t_fix;

   // points: start + d*param, round half up, saturate
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pr1_ff[k] <= $signed(ctx_ff[T2+LD].d1[k]) * $signed({1'b0, s_fin});
            pr2_ff[k] <= $signed(ctx_ff[T2+LD].d2[k]) * $signed({1'b0, t_fin});
            st1_ff[k] <= ctx_ff[T2+LD].p1[k];
            st2_ff[k] <= ctx_ff[T2+LD].p2[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [PTW-1:0] v1;
      logic [PTW-1:0] v2;
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            v1 = (PTW'($signed(st1_ff[k])) <<< PF) + PTW'($signed(pr1_ff[k]))
                 + (PTW'(1) << (PF - 1));
            v2 = (PTW'($signed(st2_ff[k])) <<< PF) + PTW'($signed(pr2_ff[k]))
                 + (PTW'(1) << (PF - 1));
            nf_ff[k] <= sat_f(v1[PTW-1:PF]);
            ns_ff[k] <= sat_f(v2[PTW-1:PF]);
         end
      end
   end

   assign rsp_near_first_x = nf_ff[0];
   assign rsp_near_first_y = nf_ff[1];
   assign rsp_near_first_z = nf_ff[2];
   assign rsp_near_second_x = ns_ff[0];
   assign rsp_near_second_y = ns_ff[1];
   assign rsp_near_second_z = ns_ff[2];

endmodule

// ===== hdl/scp_mul.sv =====
// pipelined signed multiplier, one chunk of the second operand per stage
module scp_mul import scp_pkg::*; #(
   parameter int WA = 36,
   parameter int WB = 36,
   parameter int CH = MUL_CHUNK
) (
   input  logic               clock,
   input  logic               en,
   input  logic [WA-1:0]      a_in,
   input  logic [WB-1:0]      b_in,
   output logic [WA+WB-1:0]   p_out
);

   localparam int NC = (WB + CH - 1) / CH;
   localparam int WBX = NC * CH;
   localparam int WP = WA + WB;

   logic [WA-1:0]  a_ff   [NC-1];
   logic [WBX-1:0] b_ff   [NC-1];
   logic [WP-1:0]  acc_ff [NC];
   logic [WBX-1:0] bx;

   assign bx = WBX'($signed(b_in));

   for (genvar k = 0; k < NC; k++) begin : g_st
      logic [WA-1:0]         a_src;
      logic [WBX-1:0]        b_src;
      logic [WP-1:0]         acc_src;
      logic signed [CH:0]    cx;
      logic signed [WA+CH:0] pp;
      logic [WP-1:0]         ppx;

      if (k == 0) begin : g_first
         assign a_src = a_in;
         assign b_src = bx;
         assign acc_src = '0;
      end else begin : g_next
         assign a_src = a_ff[k-1];
         assign b_src = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end

      // top chunk carries the sign
      if (k == NC - 1) begin : g_top
         assign cx = {b_src[k*CH+CH-1], b_src[k*CH +: CH]};
      end else begin : g_low
         assign cx = {1'b0, b_src[k*CH +: CH]};
      end

      assign pp = $signed(a_src) * cx;
      assign ppx = WP'(pp) << (k * CH);

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_src + ppx;
         end
      end

      if (k < NC - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k] <= a_src;
               b_ff[k] <= b_src;
            end
         end
      end
   end

   assign p_out = acc_ff[NC-1];

endmodule

// ===== hdl/scp_div.sv =====
// pipelined clamped divider, one quotient bit per stage
module scp_div import scp_pkg::*; #(
   parameter int W = 64,
   parameter int QB = PARAM_FRAC
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  num_in,
   input  logic [W-1:0]  den_in,
   output logic [QB:0]   q_out
);

   logic          zero_ff [QB+1];
   logic          one_ff  [QB+1];
   logic [W-1:0]  r_ff    [QB];
   logic [W-1:0]  d_ff    [QB];
   logic [QB-1:0] q_ff    [1:QB];

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= ($signed(den_in) <= 0) || ($signed(num_in) <= 0);
         one_ff[0] <= $signed(num_in) >= $signed(den_in);
         r_ff[0] <= num_in;
         d_ff[0] <= den_in;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_it
      logic [W-1:0] r2;
      logic         ge;

      assign r2 = {r_ff[k-1][W-2:0], 1'b0};
      assign ge = r2 >= d_ff[k-1];

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[k] <= zero_ff[k-1];
            one_ff[k] <= one_ff[k-1];
         end
      end

      if (k == 1) begin : g_q0
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[k] <= {{(QB-1){1'b0}}, ge};
            end
         end
      end else begin : g_qn
         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[k] <= {q_ff[k-1][QB-2:0], ge};
            end
         end
      end

      if (k < QB) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[k] <= ge ? (r2 - d_ff[k-1]) : r2;
               d_ff[k] <= d_ff[k-1];
            end
         end
      end
   end

   assign q_out = zero_ff[QB] ? '0 :
                  one_ff[QB]  ? {1'b1, {QB{1'b0}}} : {1'b0, q_ff[QB]};

endmodule

// ===== hdl/scp_checker.sv =====
// port-level checks for the segment closest points unit, with bind
module scp_checker import scp_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COORD_BITS-1:0] rsp_near_first_x
);

   // held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_near_first_x))
      else $error("stalled result changed");

   // input only backs up behind a stalled result
   a_req_stall: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind segment_closest_points_unit scp_checker #(.COORD_BITS(COORD_BITS)) u_scp_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_near_first_x(rsp_near_first_x)
);
